>>> hw/rtl/swm_pkg.sv
package swm_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int SAMPLE_W       = 32;
  localparam int MED_W          = 33;
  localparam int CFG_W          = 7;

  localparam logic [CFG_W-1:0] WS_RESET = CFG_W'(3);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MED_W-1:0]    median_t;
  typedef logic        [CFG_W-1:0]    wsize_t;

  // per-cell status handed to neighbors
  typedef struct packed {
    logic le;     // held value <= incoming sample
    logic rm_ge;  // the leaving entry sits at or left of this cell
  } swm_flags_t;

endpackage

>>> hw/rtl/swm_if.sv
interface swm_in_if;
  import swm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if;
  import swm_pkg::*;

  logic    valid;
  logic    ready;
  median_t median_halves;

  modport source (output valid, output median_halves, input ready);
  modport sink   (input valid, input median_halves, output ready);
endinterface

>>> hw/rtl/swm_cell.sv
module swm_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7,
  parameter int AW  = 6
) (
  input  logic                 clk,
  input  logic                 upd,
  input  swm_pkg::sample_t     s,
  input  logic                 full,
  input  logic [CW-1:0]        k,
  input  logic [AW-1:0]        k_m1,
  input  logic [CW-1:0]        len,
  input  swm_pkg::sample_t     l_val,
  input  logic [AW-1:0]        l_age,
  input  swm_pkg::swm_flags_t  l_flg,
  input  swm_pkg::sample_t     r_val,
  input  logic [AW-1:0]        r_age,
  input  swm_pkg::swm_flags_t  r_flg,
  output swm_pkg::sample_t     val,
  output logic [AW-1:0]        age,
  output swm_pkg::swm_flags_t  flg
);
  import swm_pkg::*;

  sample_t         val_r, val_nxt;
  logic [AW-1:0]   age_r, age_nxt;
  logic            le_own, old, rm_in, rm_ge;
  sample_t         wi_val, wp_val;
  logic [AW-1:0]   wi_age, wp_age;
  logic            wi_le, wp_le, wi_ok;

  always_comb begin
    rm_in  = l_flg.rm_ge;
    le_own = (val_r <= s);
    old    = full && (CW'(IDX) < k) && (age_r == k_m1);
    rm_ge  = rm_in | old;

    // entry at this slot and the one before it, with the leaving entry closed up
    wi_val = rm_ge ? r_val : val_r;
    wi_age = rm_ge ? r_age : age_r;
    wi_le  = rm_ge ? r_flg.le : le_own;
    wi_ok  = CW'(IDX) < len;
    wp_val = rm_in ? val_r : l_val;
    wp_age = rm_in ? age_r : l_age;
    wp_le  = rm_in ? le_own : l_flg.le;

    if (wi_ok && wi_le) begin
      val_nxt = wi_val;
      age_nxt = wi_age + AW'(1);
    end else if (wp_le) begin
      val_nxt = s;
      age_nxt = '0;
    end else begin
      val_nxt = wp_val;
      age_nxt = wp_age + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val       = val_r;
  assign age       = age_r;
  assign flg.le    = le_own;
  assign flg.rm_ge = rm_ge;

endmodule

>>> hw/rtl/sliding_window_median.sv
// channel   dir  payload                 handshake
// in_ch     in   sample [31:0] signed    valid/ready
// out_ch    out  median_halves [32:0] s  valid/ready
// cfg_*     in   window_size [6:0]       cfg_we, no wait
//
// One word per clock: a chain of WINDOW_MAX cells keeps the window sorted, each
// cell also holding its entry's age; insert and eviction happen in the accept cycle.
// The median is picked from the chain into the output register once that register is free.
// Synchronous active-low reset; window size 3, window empty.
// A stalled output holds one result and one pending pick; in_ch.ready then drops.
module sliding_window_median #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  swm_in_if.sink               in_ch,
  swm_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  swm_pkg::wsize_t      cfg_wdata
);
  import swm_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW = (CW > CFG_W) ? CW : CFG_W;

  wsize_t          ws_r;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic            pend_r, pend_nxt;
  logic            ovld_r, ovld_nxt;
  median_t         odat_r, odat_nxt;

  logic [KW-1:0]   ws_ext, kx;
  logic [CW-1:0]   k, len;
  logic [AW-1:0]   k_m1, idx_hi, idx_lo;
  logic            full, produce, accept, out_free;
  sample_t         med_lo, med_hi;

  sample_t             cell_val [WINDOW_MAX];
  logic [AW-1:0]       cell_age [WINDOW_MAX];
  swm_flags_t          cell_flg [WINDOW_MAX];

  always_comb begin
    ws_ext = KW'(ws_r);
    if (ws_ext == '0) begin
      kx = KW'(1);
    end else if (ws_ext > KW'(WINDOW_MAX)) begin
      kx = KW'(WINDOW_MAX);
    end else begin
      kx = ws_ext;
    end
    k       = CW'(kx);
    k_m1    = AW'(k - CW'(1));
    full    = (fill_r == k);
    len     = full ? (k - CW'(1)) : fill_r;
    produce = full || ((fill_r + CW'(1)) == k);
    idx_hi  = AW'(k >> 1);
    idx_lo  = k[0] ? idx_hi : (idx_hi - AW'(1));
  end

  assign out_free    = !ovld_r || out_ch.ready;
  assign in_ch.ready = !pend_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  generate
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      sample_t     lv, rv;
      logic [AW-1:0] la, ra;
      swm_flags_t  lf, rf;

      if (i == 0) begin : g_first
        assign lv = '0;
        assign la = '0;
        assign lf = '{le: 1'b1, rm_ge: 1'b0};
      end else begin : g_mid_l
        assign lv = cell_val[i-1];
        assign la = cell_age[i-1];
        assign lf = cell_flg[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
        assign rv = '0;
        assign ra = '0;
        assign rf = '{le: 1'b0, rm_ge: 1'b0};
      end else begin : g_mid_r
        assign rv = cell_val[i+1];
        assign ra = cell_age[i+1];
        assign rf = cell_flg[i+1];
      end

      swm_cell #(.IDX(i), .CW(CW), .AW(AW)) u_cell (
        .clk   (clk),
        .upd   (accept),
        .s     (in_ch.sample),
        .full  (full),
        .k     (k),
        .k_m1  (k_m1),
        .len   (len),
        .l_val (lv),
        .l_age (la),
        .l_flg (lf),
        .r_val (rv),
        .r_age (ra),
        .r_flg (rf),
        .val   (cell_val[i]),
        .age   (cell_age[i]),
        .flg   (cell_flg[i])
      );
    end
  endgenerate

  always_comb begin
    med_lo = '0;
    med_hi = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (AW'(i) == idx_lo) begin
        med_lo = med_lo | cell_val[i];
      end
      if (AW'(i) == idx_hi) begin
        med_hi = med_hi | cell_val[i];
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (accept && !full) begin
      fill_nxt = fill_r + CW'(1);
    end
    pend_nxt = accept ? produce : (pend_r && !out_free);
    ovld_nxt = ovld_r;
    odat_nxt = odat_r;
    if (pend_r && out_free) begin
      ovld_nxt = 1'b1;
      odat_nxt = {med_lo[SAMPLE_W-1], med_lo} + {med_hi[SAMPLE_W-1], med_hi};
    end else if (out_ch.ready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= WS_RESET;
      fill_r <= '0;
      pend_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ovld_r <= ovld_nxt;
      if (cfg_we) begin
        ws_r   <= cfg_wdata;
        fill_r <= '0;
      end else begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    odat_r <= odat_nxt;
  end

  assign out_ch.valid         = ovld_r;
  assign out_ch.median_halves = odat_r;

endmodule

>>> dv/tb_sliding_window_median.sv
`timescale 1ns / 100ps

module tb_sliding_window_median;
  import swm_pkg::*;

  localparam int unsigned WIN_MAX = WINDOW_MAX_DEF;
  localparam sample_t S_MAX = sample_t'(32'h7FFF_FFFF);
  localparam sample_t S_MIN = sample_t'(32'h8000_0000);

  logic    clk;
  logic    rst_n;
  logic    cfg_we;
  wsize_t  cfg_wdata;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  sliding_window_median u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // window shadow
  wsize_t      win_reg;
  int unsigned fill_cnt;
  int unsigned oldest_idx;
  sample_t     ring [WIN_MAX];
  sample_t     sorted_q [$];
  median_t     expected_medians [$];

  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cnt   = 0;

  function automatic int unsigned eff_window(input wsize_t w);
    if (w == 0) return 1;
    if (w > WIN_MAX) return WIN_MAX;
    return w;
  endfunction

  function automatic void queue_median(input median_t m);
    expected_medians = {expected_medians, m};
  endfunction

  function automatic void predict_median(input sample_t s);
    int unsigned k;
    int unsigned pos;
    int unsigned op;
    k = eff_window(win_reg);
    if (fill_cnt < k) begin
      ring[fill_cnt] = s;
      fill_cnt++;
      pos = 0;
      while (pos < sorted_q.size() && sorted_q[pos] <= s) pos++;
      sorted_q.insert(pos, s);
      if (fill_cnt < k) return;
      oldest_idx = 0;
    end else begin
      op = (oldest_idx >= k) ? 0 : oldest_idx;
      pos = 0;
      while (pos < sorted_q.size() && sorted_q[pos] != ring[op]) pos++;
      if (pos < sorted_q.size()) sorted_q.delete(pos);
      pos = 0;
      while (pos < sorted_q.size() && sorted_q[pos] <= s) pos++;
      sorted_q.insert(pos, s);
      ring[op] = s;
      op++;
      oldest_idx = (op >= k) ? 0 : op;
    end
    if (k % 2 == 1)
      queue_median(median_t'(sorted_q[k/2]) + median_t'(sorted_q[k/2]));
    else
      queue_median(median_t'(sorted_q[k/2-1]) + median_t'(sorted_q[k/2]));
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  task automatic check_median(input median_t got);
    median_t want;
    if (expected_medians.size() == 0) begin
      report_mismatch($sformatf("median word %0d with none expected", got));
    end else begin
      want = expected_medians.pop_front();
      if (got !== want)
        report_mismatch($sformatf("median_halves got %0d want %0d", got, want));
    end
  endtask

  // result side: checks every accepted word, drives ready
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_median(out_ch.median_halves);
      if (hold_off_cnt > 0) begin
        hold_off_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_median(s);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    // a filling word yields nothing; give the pick stage time to settle
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window(input wsize_t w);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we     <= 1'b0;
    win_reg    = w;
    fill_cnt   = 0;
    oldest_idx = 0;
    sorted_q.delete();
  endtask

  function automatic sample_t rand_sample();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: begin
        return $urandom_range(1) ? S_MAX : S_MIN;
      end
      1, 2: begin
        return sample_t'(int'($urandom_range(16)) - 8);
      end
      3: begin
        return $urandom_range(1) ? S_MAX - sample_t'($urandom_range(3))
                                 : S_MIN + sample_t'($urandom_range(3));
      end
      default: begin
        return sample_t'($urandom);
      end
    endcase
  endfunction

  function automatic wsize_t rand_window();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return wsize_t'($urandom_range(127));
    if (sel == 1) return wsize_t'(WIN_MAX);
    return wsize_t'($urandom_range(1, 8));
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // reset size of 3: extremes, signs, duplicates
  task automatic test_default_window();
    sample_t seq [$];
    set_idling(0, 0);
    seq = '{S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, sample_t'(0), sample_t'(-1),
            sample_t'(1), sample_t'(5), sample_t'(5), sample_t'(5), sample_t'(-5),
            sample_t'(5), S_MIN + 1, S_MAX - 1, sample_t'(0), sample_t'(0), S_MIN,
            sample_t'(0)};
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // zero, one, even, full and oversized windows
  task automatic test_window_extremes();
    wsize_t sizes [$];
    int unsigned n;
    set_idling(0, 0);
    sizes = '{wsize_t'(0), wsize_t'(1), wsize_t'(2), wsize_t'(64), wsize_t'(127),
              wsize_t'(65), wsize_t'(2)};
    foreach (sizes[i]) begin
      set_window(sizes[i]);
      n = eff_window(sizes[i]) + 8;
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(S_MAX);
      repeat (n) send_sample(rand_sample());
    end
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned n;
    wsize_t w;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(83, 0);
        2: set_idling(0, 83);
        default: set_idling(20, 20);
      endcase
      sent = 0;
      while (sent < 80) begin
        w = rand_window();
        set_window(w);
        n = eff_window(w) + $urandom_range(10, 50);
        repeat (n) send_sample(rand_sample());
        sent += n;
      end
    end
  endtask

  // long receiver hold-off with the sender streaming: input must stall
  task automatic test_backpressure();
    set_idling(0, 0);
    set_window(wsize_t'(5));
    hold_off_cnt = 300;
    repeat (40) send_sample(rand_sample());
    set_idling(20, 20);
    hold_off_cnt = 150;
    repeat (40) send_sample(rand_sample());
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    win_reg    = WS_RESET;
    fill_cnt   = 0;
    oldest_idx = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_window();
    test_window_extremes();
    test_random_traffic();
    test_backpressure();

    set_idling(0, 0);
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sliding_window_median regression: pass");
    end else begin
      $display("sliding_window_median regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sliding_window_median regression: fail");
    $finish;
  end

endmodule
